// ----- src/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console character writer: item
// structs, request and character codes, status codes and reset colors.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // default geometry
  localparam int DEF_SCREEN_WIDTH  = 80;
  localparam int DEF_SCREEN_HEIGHT = 25;
  localparam int DEF_TAB_STEP      = 4;

  // request types
  localparam logic [1:0] REQ_CHAR  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // character codes with an effect on the cursor
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // status codes
  localparam logic [7:0] STAT_PASS  = 8'd1;
  localparam logic [7:0] STAT_FAIL  = 8'd2;
  localparam logic [7:0] STAT_TRACE = 8'd3;

  // configuration register indexes
  localparam logic [1:0] REG_NORMAL_COLOUR = 2'd0;
  localparam logic [1:0] REG_PASS_COLOUR   = 2'd1;
  localparam logic [1:0] REG_FAIL_COLOUR   = 2'd2;
  localparam logic [1:0] REG_TRACE_COLOUR  = 2'd3;

  // reset colors
  localparam logic [7:0] RST_NORMAL_COLOUR = 8'd7;
  localparam logic [7:0] RST_PASS_COLOUR   = 8'd10;
  localparam logic [7:0] RST_FAIL_COLOUR   = 8'd12;
  localparam logic [7:0] RST_TRACE_COLOUR  = 8'd14;

  localparam logic [15:0] BLANK_RESET = {RST_NORMAL_COLOUR, CH_SPACE};

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [7:0] status;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } req_item_t;

  typedef struct packed {
    logic [15:0] cell_entry;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic        scrolled;
  } rsp_item_t;

  typedef struct packed {
    logic do_write;
    logic scroll;
    logic clear;
  } cursor_ctl_t;

endpackage

// ----- src/tcw_cursor.sv -----
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor update for one request: next logical row and column, next physical
// row in the circular screen store, the cell to write and the scroll/clear
// flags.
// ----------------------------------------------------------------------------
module tcw_cursor #(
  parameter int SCREEN_WIDTH  = tcw_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tcw_pkg::DEF_SCREEN_HEIGHT,
  parameter int TAB_STEP      = tcw_pkg::DEF_TAB_STEP
) (
  input  logic [1:0]                         req_type,
  input  logic [7:0]                         char_code,
  input  logic [$clog2(SCREEN_HEIGHT)-1:0]   row,
  input  logic [$clog2(SCREEN_WIDTH+1)-1:0]  col,
  input  logic [$clog2(SCREEN_HEIGHT)-1:0]   phys,
  output logic [$clog2(SCREEN_HEIGHT)-1:0]   row_next,
  output logic [$clog2(SCREEN_WIDTH+1)-1:0]  col_next,
  output logic [$clog2(SCREEN_HEIGHT)-1:0]   phys_next,
  output logic [$clog2(SCREEN_HEIGHT)-1:0]   wr_phys,
  output logic [$clog2(SCREEN_WIDTH+1)-1:0]  wr_col,
  output tcw_pkg::cursor_ctl_t               ctl
);
  import tcw_pkg::*;

  localparam int ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int COL_W = $clog2(SCREEN_WIDTH + 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [COL_W-1:0] COL_END  = COL_W'(SCREEN_WIDTH);
  localparam logic [COL_W:0]   TAB_ADD  = (COL_W+1)'(TAB_STEP);
  localparam logic [COL_W:0]   TAB_MAX  = (COL_W+1)'(SCREEN_WIDTH);

  logic [ROW_W-1:0] phys_inc;
  logic [ROW_W-1:0] row_adv;
  logic [COL_W:0]   tab_sum;
  logic             pre_wrap;
  logic [ROW_W-1:0] r1;
  logic [ROW_W-1:0] p1;
  logic [ROW_W-1:0] p1_inc;
  logic [COL_W-1:0] c1;
  logic [COL_W-1:0] c2;

  always_comb begin
    phys_inc = (phys == ROW_LAST) ? '0 : phys + 1'b1;
    row_adv  = (row == ROW_LAST) ? row : row + 1'b1;
    tab_sum  = {1'b0, col} + TAB_ADD;
    pre_wrap = (col >= COL_END);
    r1       = pre_wrap ? row_adv : row;
    p1       = pre_wrap ? phys_inc : phys;
    c1       = pre_wrap ? '0 : col;
    p1_inc   = (p1 == ROW_LAST) ? '0 : p1 + 1'b1;
    c2       = c1 + 1'b1;
  end

  always_comb begin
    row_next  = row;
    col_next  = col;
    phys_next = phys;
    wr_phys   = p1;
    wr_col    = c1;
    ctl       = '0;
    case (req_type)
      REQ_CHAR: begin
        case (char_code)
          CH_NEWLINE: begin
            col_next   = '0;
            row_next   = row_adv;
            phys_next  = phys_inc;
            ctl.scroll = (row == ROW_LAST);
          end
          CH_RETURN: begin
            col_next = '0;
          end
          CH_BACKSPACE: begin
            if (col != '0) begin
              col_next = col - 1'b1;
            end
          end
          CH_TAB: begin
            col_next = (tab_sum > TAB_MAX) ? COL_END : tab_sum[COL_W-1:0];
          end
          default: begin
            ctl.do_write = 1'b1;
            // wrap pending from a tab: move to next line before the write
            ctl.scroll   = pre_wrap && (row == ROW_LAST);
            if (c2 >= COL_END) begin
              col_next   = '0;
              row_next   = (r1 == ROW_LAST) ? r1 : r1 + 1'b1;
              phys_next  = p1_inc;
              ctl.scroll = ctl.scroll || (r1 == ROW_LAST);
            end else begin
              col_next  = c2;
              row_next  = r1;
              phys_next = p1;
            end
          end
        endcase
      end
      REQ_CLEAR: begin
        row_next  = '0;
        col_next  = '0;
        phys_next = '0;
        ctl.clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/text_console_character_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_character_writer
// Character-cell text console with a cursor, scrolling and cell read-back.
//
// Requests enter on req_valid/req_data, held under req_stall; each gives one
// result on rsp_valid/rsp_data, held while rsp_stall is high. Colors are set
// through cfg_we/cfg_index/cfg_data.
// The screen store is one memory used as a ring of rows; a top-row pointer
// turns a scroll into blanking one row instead of moving the screen.
// A request moves from ST_IDLE through ST_DECODE to ST_FINISH, where the
// result is loaded. A scroll adds ST_SWEEP, blanking one row, and ST_WRITE
// when a character is written with it; a clear sweeps the whole store. Both
// sweeps are paced by the single write port. A new request is taken only
// once the last one has left ST_FINISH.
// After reset the store is blanked one cell a cycle, with req_stall high;
// configuration writes are taken meanwhile.
// A result held under rsp_stall does not block the next transfer; that
// request's result waits until the output register is free.
// ----------------------------------------------------------------------------
module text_console_character_writer #(
  parameter int SCREEN_WIDTH  = tcw_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tcw_pkg::DEF_SCREEN_HEIGHT,
  parameter int TAB_STEP      = tcw_pkg::DEF_TAB_STEP
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  tcw_pkg::req_item_t  req_data,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output tcw_pkg::rsp_item_t  rsp_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import tcw_pkg::*;

  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);
  localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int RSUM_W = ((ROW_W > 5) ? ROW_W : 5) + 1;
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [RSUM_W-1:0] RSUM_H     = RSUM_W'(SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0] ADDR_WIDTH = ADDR_W'(SCREEN_WIDTH);
  localparam logic [ADDR_W-1:0] ROW_SPAN   = ADDR_W'(SCREEN_WIDTH - 1);
  localparam logic [ADDR_W-1:0] ALL_SPAN   = ADDR_W'(CELLS - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_WRITE  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [15:0] screen_mem [CELLS];

  logic [7:0] normal_colour;
  logic [7:0] pass_colour;
  logic [7:0] fail_colour;
  logic [7:0] trace_colour;

  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_phys;
  logic [ROW_W-1:0] top_row;
  logic [ROW_W-1:0] top_inc;

  req_item_t        req;
  logic [ROW_W-1:0] read_phys;
  logic             read_ok;
  logic             scrolled;
  logic             pend_write;
  logic             item_open;

  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] sweep_left;
  logic [15:0]       blank_cell;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic [15:0]       rd_data;

  logic [RSUM_W-1:0] rsum;
  logic              req_read_ok;

  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] phys_next;
  logic [ROW_W-1:0] wr_phys;
  logic [COL_W-1:0] wr_col;
  cursor_ctl_t      ctl;

  logic              is_read;
  logic [ROW_W-1:0]  addr_row;
  logic [COL_W-1:0]  addr_col;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] blank_base;
  logic [7:0]        char_colour;
  logic [15:0]       wr_now;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic              rsp_load;

  tcw_cursor #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TAB_STEP      (TAB_STEP)
  ) u_cursor (
    .req_type  (req.req_type),
    .char_code (req.char_code),
    .row       (cur_row),
    .col       (cur_col),
    .phys      (cur_phys),
    .row_next  (row_next),
    .col_next  (col_next),
    .phys_next (phys_next),
    .wr_phys   (wr_phys),
    .wr_col    (wr_col),
    .ctl       (ctl)
  );

  assign req_stall = (state != ST_IDLE);

  // physical row of a read, valid when the row is on screen
  always_comb begin
    rsum = RSUM_W'(req_data.read_row) + RSUM_W'(top_row);
    if (rsum >= RSUM_H) begin
      rsum = rsum - RSUM_H;
    end
    req_read_ok = (int'(req_data.read_row) < SCREEN_HEIGHT) &&
                  (int'(req_data.read_column) < SCREEN_WIDTH);
  end

  assign top_inc = (top_row == ROW_LAST) ? '0 : top_row + 1'b1;

  always_comb begin
    is_read    = (req.req_type == REQ_READ);
    addr_row   = is_read ? read_phys : wr_phys;
    addr_col   = is_read ? COL_W'(req.read_column) : wr_col;
    cell_addr  = ADDR_W'(ADDR_W'(addr_row) * ADDR_WIDTH) + ADDR_W'(addr_col);
    blank_base = ADDR_W'(ADDR_W'(phys_next) * ADDR_WIDTH);
    case (req.status)
      STAT_PASS:  char_colour = pass_colour;
      STAT_FAIL:  char_colour = fail_colour;
      STAT_TRACE: char_colour = trace_colour;
      default:    char_colour = normal_colour;
    endcase
    wr_now = {char_colour, req.char_code};
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = sweep_addr;
    mem_wdata  = blank_cell;
    mem_re     = 1'b0;
    rsp_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (ctl.clear || ctl.scroll) begin
          state_next = ST_SWEEP;
        end else begin
          state_next = ST_FINISH;
          if (ctl.do_write) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr;
            mem_wdata = wr_now;
          end
          mem_re = is_read && read_ok;
        end
      end
      ST_SWEEP: begin
        mem_we = 1'b1;
        if (sweep_left == '0) begin
          if (pend_write) begin
            state_next = ST_WRITE;
          end else if (item_open) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_WRITE: begin
        mem_we     = 1'b1;
        mem_waddr  = wr_addr;
        mem_wdata  = wr_data;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // screen store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= screen_mem[cell_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      normal_colour <= RST_NORMAL_COLOUR;
      pass_colour   <= RST_PASS_COLOUR;
      fail_colour   <= RST_FAIL_COLOUR;
      trace_colour  <= RST_TRACE_COLOUR;
      cur_row       <= '0;
      cur_col       <= '0;
      cur_phys      <= '0;
      top_row       <= '0;
      scrolled      <= 1'b0;
      pend_write    <= 1'b0;
      item_open     <= 1'b0;
      sweep_addr    <= '0;
      sweep_left    <= ALL_SPAN;
      blank_cell    <= BLANK_RESET;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_NORMAL_COLOUR: normal_colour <= cfg_data;
          REG_PASS_COLOUR:   pass_colour   <= cfg_data;
          REG_FAIL_COLOUR:   fail_colour   <= cfg_data;
          REG_TRACE_COLOUR:  trace_colour  <= cfg_data;
          default: begin
          end
        endcase
      end
      case (state)
        ST_DECODE: begin
          item_open  <= 1'b1;
          cur_row    <= row_next;
          cur_col    <= col_next;
          cur_phys   <= phys_next;
          scrolled   <= ctl.scroll;
          pend_write <= ctl.do_write && ctl.scroll;
          blank_cell <= {normal_colour, CH_SPACE};
          if (ctl.clear) begin
            top_row    <= '0;
            sweep_addr <= '0;
            sweep_left <= ALL_SPAN;
          end else begin
            if (ctl.scroll) begin
              top_row <= top_inc;
            end
            sweep_addr <= blank_base;
            sweep_left <= ROW_SPAN;
          end
        end
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          sweep_left <= sweep_left - 1'b1;
        end
        ST_FINISH: begin
          if (rsp_load) begin
            item_open <= 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      req       <= req_data;
      read_phys <= rsum[ROW_W-1:0];
      read_ok   <= req_read_ok;
    end
    if (state == ST_DECODE) begin
      wr_addr <= cell_addr;
      wr_data <= wr_now;
    end
    if (rsp_load) begin
      rsp_data.cell_entry    <= (is_read && read_ok) ? rd_data : '0;
      rsp_data.cursor_row    <= 5'(cur_row);
      rsp_data.cursor_column <= 7'(cur_col);
      rsp_data.scrolled      <= scrolled;
    end
  end

endmodule

// ----- bench/tcw_checker.sv -----
// ----------------------------------------------------------------------------
// tcw_checker
// Watches the request, result and color ports of the text console character
// writer. Each request transfer is run through a local copy of the screen,
// the cursor and the colors, and the predicted reply is queued. Every result
// transfer is compared field by field with the oldest queued reply.
// ----------------------------------------------------------------------------
module tcw_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  tcw_pkg::req_item_t req_data,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  tcw_pkg::rsp_item_t rsp_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 errors,
  output int                 outstanding
);
  import tcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W     = DEF_SCREEN_WIDTH;
  localparam int H     = DEF_SCREEN_HEIGHT;
  localparam int TAB   = DEF_TAB_STEP;
  localparam int CELLS = W * H;

  logic [15:0] screen_copy [CELLS];
  int          cur_row;
  int          cur_col;
  logic [7:0]  normal_colour;
  logic [7:0]  pass_colour;
  logic [7:0]  fail_colour;
  logic [7:0]  trace_colour;
  rsp_item_t   expected_replies [$];
  int          fail_tally = 0;

  function automatic logic [7:0] colour_for(logic [7:0] st);
    case (st)
      STAT_PASS:  return pass_colour;
      STAT_FAIL:  return fail_colour;
      STAT_TRACE: return trace_colour;
      default:    return normal_colour;
    endcase
  endfunction

  task automatic blank_screen();
    for (int i = 0; i < CELLS; i++) screen_copy[i] = {normal_colour, CH_SPACE};
  endtask

  // move to column 0 of the next row, scrolling off the top row if needed
  function automatic bit next_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= H) begin
      for (int i = 0; i < CELLS - W; i++) screen_copy[i] = screen_copy[i + W];
      for (int i = CELLS - W; i < CELLS; i++) screen_copy[i] = {normal_colour, CH_SPACE};
      cur_row = H - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic apply_request(input req_item_t r, output rsp_item_t o);
    logic [15:0] entry;
    bit          rolled;
    entry  = '0;
    rolled = 1'b0;
    case (r.req_type)
      REQ_CHAR: begin
        if (r.char_code == CH_NEWLINE) begin
          rolled = next_row();
        end else if (r.char_code == CH_RETURN) begin
          cur_col = 0;
        end else if (r.char_code == CH_BACKSPACE) begin
          if (cur_col > 0) cur_col--;
        end else if (r.char_code == CH_TAB) begin
          cur_col += TAB;
          if (cur_col > W) cur_col = W;
        end else begin
          // pending wrap is taken before the write
          if (cur_col >= W) rolled |= next_row();
          screen_copy[cur_row * W + cur_col] = {colour_for(r.status), r.char_code};
          cur_col++;
          if (cur_col >= W) rolled |= next_row();
        end
      end
      REQ_READ: begin
        if (int'(r.read_row) < H && int'(r.read_column) < W)
          entry = screen_copy[int'(r.read_row) * W + int'(r.read_column)];
      end
      REQ_CLEAR: begin
        blank_screen();
        cur_row = 0;
        cur_col = 0;
      end
      default: begin
      end
    endcase
    o.cell_entry    = entry;
    o.cursor_row    = cur_row[4:0];
    o.cursor_column = cur_col[6:0];
    o.scrolled      = rolled;
  endtask

  always @(posedge clk) begin : watch
    rsp_item_t want;
    rsp_item_t got;
    if (rst) begin
      normal_colour = RST_NORMAL_COLOUR;
      pass_colour   = RST_PASS_COLOUR;
      fail_colour   = RST_FAIL_COLOUR;
      trace_colour  = RST_TRACE_COLOUR;
      blank_screen();
      cur_row = 0;
      cur_col = 0;
      expected_replies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NORMAL_COLOUR: normal_colour = cfg_data;
          REG_PASS_COLOUR:   pass_colour   = cfg_data;
          REG_FAIL_COLOUR:   fail_colour   = cfg_data;
          REG_TRACE_COLOUR:  trace_colour  = cfg_data;
          default: begin
          end
        endcase
      end
      if (req_valid && !req_stall) begin
        apply_request(req_data, want);
        expected_replies.push_back(want);
      end
      if (rsp_valid && !rsp_stall) begin
        got = rsp_data;
        if (expected_replies.size() == 0) begin
          $error("result transfer with no request waiting: %h", got);
          fail_tally++;
        end else begin
          want = expected_replies.pop_front();
          if (got.cell_entry !== want.cell_entry) begin
            $error("cell_entry expected %h actual %h", want.cell_entry, got.cell_entry);
            fail_tally++;
          end
          if (got.cursor_row !== want.cursor_row) begin
            $error("cursor_row expected %0d actual %0d", want.cursor_row, got.cursor_row);
            fail_tally++;
          end
          if (got.cursor_column !== want.cursor_column) begin
            $error("cursor_column expected %0d actual %0d",
                   want.cursor_column, got.cursor_column);
            fail_tally++;
          end
          if (got.scrolled !== want.scrolled) begin
            $error("scrolled expected %b actual %b", want.scrolled, got.scrolled);
            fail_tally++;
          end
        end
      end
    end
    errors      <= fail_tally;
    outstanding <= expected_replies.size();
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the text console character writer: a short directed run with
// the reset colors, then random phases of typed text, tab and backspace
// runs, newline runs, cell reads, clears and noise, each phase under new
// colors. Both sides idle at random; once the result side holds off long
// enough to back the block up. The checker beside the block gives the count.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         W             = DEF_SCREEN_WIDTH;
  localparam int         H             = DEF_SCREEN_HEIGHT;
  localparam logic [1:0] REQ_UNUSED    = 2'd3;
  localparam int         PHASE_ITEMS   = 400;
  localparam int         PRESSURE_HOLD = 600;
  localparam int         DRAIN_CYCLES  = W * H + 2 * W + 16;
  localparam int         LIMIT_CYCLES  = 2_000_000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_item_t  req_data  = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_item_t  rsp_data;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = REG_NORMAL_COLOUR;
  logic [7:0] cfg_data  = '0;
  int         errors;
  int         outstanding;

  int         sent;
  int         cycles = 0;
  bit         calm;
  bit         squeeze;
  bit         squeeze_done = 1'b0;
  int         hold_left;
  int         calm_left;

  text_console_character_writer dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tcw_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_data    (rsp_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("text_console_character_writer test failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // result side: random stalls, calm stretches and one long hold-off
  always @(posedge clk) begin : receiver
    int r;
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left = 0;
      calm_left = 0;
    end else if (squeeze && !squeeze_done) begin
      squeeze_done = 1'b1;
      hold_left    = PRESSURE_HOLD - 1;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      rsp_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        calm_left = $urandom_range(20, 200);
        rsp_stall <= 1'b0;
      end else if (r < 40) begin
        hold_left = idle_gap();
        rsp_stall <= (hold_left > 0);
        if (hold_left > 0) hold_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic req_item_t fresh_item(logic [1:0] kind);
    logic [31:0] bits;
    req_item_t   it;
    bits        = $urandom;
    it          = bits[29:0];
    it.req_type = kind;
    return it;
  endfunction

  function automatic req_item_t char_item(logic [7:0] ch, logic [7:0] st);
    req_item_t it;
    it           = fresh_item(REQ_CHAR);
    it.char_code = ch;
    it.status    = st;
    return it;
  endfunction

  function automatic req_item_t read_item(logic [4:0] row, logic [6:0] col);
    req_item_t it;
    it             = fresh_item(REQ_READ);
    it.read_row    = row;
    it.read_column = col;
    return it;
  endfunction

  function automatic logic [7:0] pick_status();
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(req_item_t it);
    int gap;
    gap = calm ? 0 : idle_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (it.req_type != REQ_UNUSED) sent++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_colour(logic [1:0] idx, logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic set_colours(logic [7:0] n, logic [7:0] s, logic [7:0] f, logic [7:0] d);
    write_colour(REG_NORMAL_COLOUR, n);
    write_colour(REG_PASS_COLOUR, s);
    write_colour(REG_FAIL_COLOUR, f);
    write_colour(REG_TRACE_COLOUR, d);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    calm = 1'b0;
    send_item(read_item(5'd0, 7'd0));
    send_item(read_item(5'(H - 1), 7'(W - 1)));
    send_item(read_item(5'(H), 7'd0));
    send_item(read_item(5'd0, 7'(W)));
    send_item(read_item(5'h1f, 7'h7f));
    // backspace at the left edge stays put
    send_item(char_item(CH_BACKSPACE, 8'd0));
    send_item(char_item("A", 8'd0));
    send_item(char_item(8'hff, STAT_PASS));
    send_item(char_item(8'h00, STAT_FAIL));
    send_item(char_item("z", STAT_TRACE));
    send_item(char_item("#", 8'hff));
    send_item(read_item(5'd0, 7'd1));
    send_item(read_item(5'd0, 7'd2));
    send_item(read_item(5'd0, 7'd4));
    send_item(char_item(CH_BACKSPACE, 8'd0));
    send_item(char_item(CH_TAB, 8'd0));
    send_item(char_item(CH_RETURN, 8'd0));
    send_item(char_item(CH_NEWLINE, 8'd0));
    send_item(fresh_item(REQ_UNUSED));
    send_item(fresh_item(REQ_CLEAR));
    send_item(read_item(5'd0, 7'd0));
    send_item(read_item(5'd0, 7'd4));
  endtask

  task automatic run_random(int quota);
    int target;
    int kind;
    int n;
    target = sent + quota;
    while (sent < target) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // line of text, some long enough to wrap
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 170) : $urandom_range(1, 40);
        repeat (n) begin
          if ($urandom_range(0, 99) < 3) send_item(char_item(CH_NEWLINE, pick_status()));
          else send_item(char_item(pick_char(), pick_status()));
        end
        if ($urandom_range(0, 1)) send_item(char_item(CH_NEWLINE, pick_status()));
      end else if (kind < 55) begin
        // tab run toward the right edge, then a character or a backspace
        if ($urandom_range(0, 1)) send_item(char_item(CH_RETURN, pick_status()));
        repeat ($urandom_range(1, 24)) send_item(char_item(CH_TAB, pick_status()));
        if ($urandom_range(0, 1)) send_item(char_item(pick_char(), pick_status()));
        else send_item(char_item(CH_BACKSPACE, pick_status()));
      end else if (kind < 63) begin
        n = $urandom_range(0, 4);
        repeat (n) send_item(char_item(pick_char(), pick_status()));
        repeat ($urandom_range(1, n + 3)) send_item(char_item(CH_BACKSPACE, pick_status()));
      end else if (kind < 68) begin
        repeat ($urandom_range(1, 30)) send_item(char_item(CH_NEWLINE, pick_status()));
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 99) < 80)
            send_item(read_item(5'($urandom_range(0, H - 1)),
                                7'($urandom_range(0, W - 1))));
          else
            send_item(read_item(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127))));
        end
      end else if (kind < 91) begin
        send_item(fresh_item(REQ_CLEAR));
      end else begin
        repeat ($urandom_range(1, 5)) send_item(fresh_item(2'($urandom_range(0, 3))));
      end
    end
  endtask

  initial begin : stimulus
    sent    = 0;
    calm    = 1'b0;
    squeeze = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: set_colours(8'h00, 8'h00, 8'h00, 8'h00);
        1: set_colours(8'hff, 8'hff, 8'hff, 8'hff);
        default: set_colours(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      if (phase == 1) squeeze = 1'b1;
      run_random(PHASE_ITEMS);
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("text_console_character_writer test passed");
    end else begin
      $display("text_console_character_writer test failed");
    end
    $finish;
  end

endmodule

// ----- text_console_character_writer.f -----
src/tcw_pkg.sv
src/tcw_cursor.sv
src/text_console_character_writer.sv
bench/tcw_checker.sv
bench/testbench.sv
